/* src/wfa_pkg.sv */
// ============================================================================
// wfa_pkg: shared types and constants of the Wiegand frame assembler
// Status codes, configuration register indexes, parity settings field layout
// and the control word that moves between pipeline stages.
// ============================================================================
package wfa_pkg;

    // Defaults of the top-level parameters.
    localparam int DEF_MAX_FRAME_BITS = 64;
    localparam int DEF_PARITY_SLOTS   = 4;

    // Fixed field widths.
    localparam int VALUE_W    = 32;   // facility code and card number
    localparam int LEN_W      = 7;    // frame length and bit counts
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int SET_W      = 31;   // parity settings register

    // Parity settings layout: one 7-bit field per slot, count in 30:28.
    localparam int PAR_FIELD_W  = 7;
    localparam int PAR_POS_W    = 6;
    localparam int PAR_ODD_BIT  = 6;
    localparam int PAR_CNT_LSB  = 28;
    localparam int PAR_CNT_W    = 3;

    localparam int DEFAULT_FRAME_LENGTH = 26;

    typedef enum logic [1:0] {
        STATUS_OK            = 2'd0,
        STATUS_FACILITY_WIDE = 2'd1,
        STATUS_CARD_WIDE     = 2'd2,
        STATUS_PARITY_POS    = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_LENGTH      = 3'd0,
        CFG_FACILITY_MASK     = 3'd1,
        CFG_CARD_MASK         = 3'd2,
        CFG_PARITY_MASK_ZERO  = 3'd3,
        CFG_PARITY_MASK_ONE   = 3'd4,
        CFG_PARITY_MASK_TWO   = 3'd5,
        CFG_PARITY_MASK_THREE = 3'd6,
        CFG_PARITY_SETTINGS   = 3'd7
    } cfg_index_t;

    // Control word that travels with each frame through the pipeline.
    typedef struct packed {
        logic    valid;
        status_t status;
    } stage_ctrl_t;

endpackage

/* src/wfa_place.sv */
// ============================================================================
// wfa_place: field width check and bit deposit
// Stage one checks that both values fit their masks; stage two spreads the
// facility code and the card number over the set bits of their masks.
// ============================================================================
module wfa_place #(
    parameter int MAX_FRAME_BITS = wfa_pkg::DEF_MAX_FRAME_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [wfa_pkg::VALUE_W-1:0]   site_code,
    input  logic [wfa_pkg::VALUE_W-1:0]   badge_number,
    input  logic [MAX_FRAME_BITS-1:0]     facility_mask,
    input  logic [MAX_FRAME_BITS-1:0]     card_mask,
    input  logic [MAX_FRAME_BITS-1:0]     span,
    output wfa_pkg::stage_ctrl_t          dn_ctrl,
    output logic [MAX_FRAME_BITS-1:0]     dn_frame,
    input  logic                          dn_ready
);

    localparam int LEN_W   = wfa_pkg::LEN_W;
    localparam int VALUE_W = wfa_pkg::VALUE_W;
    localparam int RANK_W  = $clog2(VALUE_W);

    logic [MAX_FRAME_BITS-1:0] fac_m;
    logic [MAX_FRAME_BITS-1:0] card_m;
    logic [LEN_W-1:0]          n_fac;
    logic [LEN_W-1:0]          n_card;
    logic                      fac_wide;
    logic                      card_wide;

    logic                      s1_valid_reg;
    wfa_pkg::status_t          s1_status_reg;
    wfa_pkg::status_t          s1_status_next;
    logic [VALUE_W-1:0]        s1_fac_reg;
    logic [VALUE_W-1:0]        s1_card_reg;
    logic                      s1_ready;
    logic                      s1_load;

    logic                      s2_valid_reg;
    wfa_pkg::status_t          s2_status_reg;
    logic [MAX_FRAME_BITS-1:0] s2_frame_reg;
    logic [MAX_FRAME_BITS-1:0] s2_frame_next;
    logic                      s2_ready;
    logic                      s2_load;

    logic [MAX_FRAME_BITS-1:0] dep_fac;
    logic [MAX_FRAME_BITS-1:0] dep_card;

    // Mask bits beyond the frame are ignored.
    assign fac_m  = facility_mask & span;
    assign card_m = card_mask & span;
    assign n_fac  = LEN_W'($countones(fac_m));
    assign n_card = LEN_W'($countones(card_m));

    // A value is too wide only for a non-empty mask of fewer than 32 bits.
    assign fac_wide  = (n_fac != '0) && (n_fac < LEN_W'(VALUE_W))
                       && ((site_code >> n_fac) != '0);
    assign card_wide = (n_card != '0) && (n_card < LEN_W'(VALUE_W))
                       && ((badge_number >> n_card) != '0);

    always_comb
    begin
        if (fac_wide)
        begin
            s1_status_next = wfa_pkg::STATUS_FACILITY_WIDE;
        end
        else if (card_wide)
        begin
            s1_status_next = wfa_pkg::STATUS_CARD_WIDE;
        end
        else
        begin
            s1_status_next = wfa_pkg::STATUS_OK;
        end
    end

    assign s2_ready   = !s2_valid_reg || dn_ready;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign item_ready = s1_ready;
    assign s1_load    = item_valid && s1_ready;
    assign s2_load    = s1_valid_reg && s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= item_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_status_reg <= s1_status_next;
            s1_fac_reg    <= site_code;
            s1_card_reg   <= badge_number;
        end
        if (s2_load)
        begin
            s2_status_reg <= s1_status_reg;
            s2_frame_reg  <= s2_frame_next;
        end
    end

    // Each frame bit takes the value bit whose rank equals the number of
    // set mask bits below it; ranks of 32 and above receive zero.
    for (genvar j = 0; j < MAX_FRAME_BITS; j++)
    begin : g_dep
        localparam logic [MAX_FRAME_BITS-1:0] LOW =
            (MAX_FRAME_BITS'(1) << j) - MAX_FRAME_BITS'(1);
        logic [LEN_W-1:0] rank_fac;
        logic [LEN_W-1:0] rank_card;

        assign rank_fac   = LEN_W'($countones(fac_m & LOW));
        assign rank_card  = LEN_W'($countones(card_m & LOW));
        assign dep_fac[j] = fac_m[j] && (rank_fac < LEN_W'(VALUE_W))
                            && s1_fac_reg[rank_fac[RANK_W-1:0]];
        assign dep_card[j] = card_m[j] && (rank_card < LEN_W'(VALUE_W))
                             && s1_card_reg[rank_card[RANK_W-1:0]];
    end

    // The card number overwrites the facility code where the masks overlap.
    always_comb
    begin
        if (s1_status_reg != wfa_pkg::STATUS_OK)
        begin
            s2_frame_next = '0;
        end
        else
        begin
            s2_frame_next = (dep_fac & ~card_m) | dep_card;
        end
    end

    assign dn_ctrl.valid  = s2_valid_reg;
    assign dn_ctrl.status = s2_status_reg;
    assign dn_frame       = s2_frame_reg;

endmodule

/* src/wfa_parity_stage.sv */
// ============================================================================
// wfa_parity_stage: one parity slot
// Checks the slot's position against the frame length and sets the parity
// bit over the slot's mask, leaving out its own position.
// ============================================================================
module wfa_parity_stage #(
    parameter int MAX_FRAME_BITS = wfa_pkg::DEF_MAX_FRAME_BITS,
    parameter int SLOT           = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  wfa_pkg::stage_ctrl_t                up_ctrl,
    input  logic [MAX_FRAME_BITS-1:0]           up_frame,
    output logic                                up_ready,
    input  logic [MAX_FRAME_BITS-1:0]           parity_mask,
    input  logic [wfa_pkg::SET_W-1:0]           parity_settings,
    input  logic [MAX_FRAME_BITS-1:0]           span,
    input  logic [wfa_pkg::LEN_W-1:0]           len_eff,
    output wfa_pkg::stage_ctrl_t                dn_ctrl,
    output logic [MAX_FRAME_BITS-1:0]           dn_frame,
    input  logic                                dn_ready
);

    localparam int FIELD_LSB = SLOT * wfa_pkg::PAR_FIELD_W;

    logic [wfa_pkg::PAR_POS_W-1:0] pos;
    logic                          odd;
    logic [wfa_pkg::PAR_CNT_W-1:0] count;
    logic                          active;
    logic                          pos_bad;
    logic [MAX_FRAME_BITS-1:0]     own;
    logic                          par_bit;

    logic                          valid_reg;
    wfa_pkg::status_t              status_reg;
    wfa_pkg::status_t              status_next;
    logic [MAX_FRAME_BITS-1:0]     frame_reg;
    logic [MAX_FRAME_BITS-1:0]     frame_next;
    logic                          load;

    assign pos    = parity_settings[FIELD_LSB +: wfa_pkg::PAR_POS_W];
    assign odd    = parity_settings[FIELD_LSB + wfa_pkg::PAR_ODD_BIT];
    assign count  = parity_settings[wfa_pkg::PAR_CNT_LSB +: wfa_pkg::PAR_CNT_W];
    // This slot is in use exactly when the raw slot count is above its number;
    // a count above the number of slots leaves every slot in use.
    assign active = count > wfa_pkg::PAR_CNT_W'(SLOT);

    assign pos_bad = {1'b0, pos} >= len_eff;
    assign own     = MAX_FRAME_BITS'(1) << pos;
    assign par_bit = (^(up_frame & parity_mask & span & ~own)) ^ odd;

    always_comb
    begin
        status_next = up_ctrl.status;
        frame_next  = up_frame;
        if ((up_ctrl.status == wfa_pkg::STATUS_OK) && active)
        begin
            if (pos_bad)
            begin
                status_next = wfa_pkg::STATUS_PARITY_POS;
                frame_next  = '0;
            end
            else
            begin
                frame_next = (up_frame & ~own) | (par_bit ? own : '0);
            end
        end
    end

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_ctrl.valid && up_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= status_next;
            frame_reg  <= frame_next;
        end
    end

    assign dn_ctrl.valid  = valid_reg;
    assign dn_ctrl.status = status_reg;
    assign dn_frame       = frame_reg;

endmodule

/* src/wiegand_frame_assembler.sv */
// ============================================================================
// wiegand_frame_assembler: Wiegand frame builder with parity
// Places a facility code and a card number into a configurable right-aligned
// frame and applies up to PARITY_SLOTS even or odd parity bits.
// ============================================================================
// Usage:
// The item channel (item_valid/item_ready) takes one word per cycle, while
// item_ready is high, holding a facility code and a card number. The result
// channel (result_valid/result_ready) returns one word per item: the frame,
// with frame bit j at bit j and the first bit sent at bit frame_length-1,
// and a status code. On any error the frame is zero and status tells which
// check failed. From acceptance to result_valid a word passes a width check
// stage, a deposit stage, then one stage per parity slot, the last of which
// is the output register. Throughput is one word per cycle while result_ready
// is high. Stall: when result_ready is low, the full stages hold their
// contents and bubbles still fill, so input is taken until every stage is
// occupied; item_ready is high whenever the output register is empty.
// Reset empties the pipeline and loads frame_length 26 with all masks and
// parity settings zero. The configuration channel is always ready. The user
// must write it only while no word is in flight; the block does not enforce it.
// ============================================================================
module wiegand_frame_assembler #(
    parameter int MAX_FRAME_BITS = wfa_pkg::DEF_MAX_FRAME_BITS,
    parameter int PARITY_SLOTS   = wfa_pkg::DEF_PARITY_SLOTS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wfa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wfa_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Item channel.
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic [wfa_pkg::VALUE_W-1:0]        site_code,
    input  logic [wfa_pkg::VALUE_W-1:0]        badge_number,
    // Result channel.
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic [MAX_FRAME_BITS-1:0]          frame,
    output logic [1:0]                         status
);

    localparam int LEN_W = wfa_pkg::LEN_W;

    // Configuration registers.
    logic [LEN_W-1:0]           frame_length_reg;
    logic [MAX_FRAME_BITS-1:0]  facility_mask_reg;
    logic [MAX_FRAME_BITS-1:0]  card_mask_reg;
    logic [MAX_FRAME_BITS-1:0]  parity_mask_reg [PARITY_SLOTS];
    logic [wfa_pkg::SET_W-1:0]  parity_settings_reg;
    logic                       cfg_write;

    // Config values; kept stable while words are in flight by the user only.
    logic [LEN_W-1:0]           len_eff;
    logic [MAX_FRAME_BITS-1:0]  span;

    // Pipeline links: entry 0 is the deposit stage output, entry k+1 the
    // output of parity slot k.
    wfa_pkg::stage_ctrl_t       link_ctrl  [PARITY_SLOTS+1];
    logic [MAX_FRAME_BITS-1:0]  link_frame [PARITY_SLOTS+1];
    logic                       link_ready [PARITY_SLOTS+1];

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg    <= LEN_W'(wfa_pkg::DEFAULT_FRAME_LENGTH);
            facility_mask_reg   <= '0;
            card_mask_reg       <= '0;
            parity_settings_reg <= '0;
            for (int k = 0; k < PARITY_SLOTS; k++)
            begin
                parity_mask_reg[k] <= '0;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                wfa_pkg::CFG_FRAME_LENGTH:
                begin
                    frame_length_reg <= cfg_data[LEN_W-1:0];
                end
                wfa_pkg::CFG_FACILITY_MASK:
                begin
                    facility_mask_reg <= cfg_data[MAX_FRAME_BITS-1:0];
                end
                wfa_pkg::CFG_CARD_MASK:
                begin
                    card_mask_reg <= cfg_data[MAX_FRAME_BITS-1:0];
                end
                wfa_pkg::CFG_PARITY_SETTINGS:
                begin
                    parity_settings_reg <= cfg_data[wfa_pkg::SET_W-1:0];
                end
                default:
                begin
                    // Parity masks; indexes of slots this build lacks are
                    // dropped, since no mask register exists for them.
                    for (int k = 0; k < PARITY_SLOTS; k++)
                    begin
                        if (cfg_index == (wfa_pkg::CFG_PARITY_MASK_ZERO
                                          + wfa_pkg::CFG_IDX_W'(k)))
                        begin
                            parity_mask_reg[k] <= cfg_data[MAX_FRAME_BITS-1:0];
                        end
                    end
                end
            endcase
        end
    end

    // A frame length above the maximum acts as the maximum; a length of zero
    // gives an empty frame, so every mask bit is ignored.
    assign len_eff = (frame_length_reg > LEN_W'(MAX_FRAME_BITS))
                     ? LEN_W'(MAX_FRAME_BITS) : frame_length_reg;
    assign span    = (len_eff >= LEN_W'(MAX_FRAME_BITS))
                     ? '1 : ((MAX_FRAME_BITS'(1) << len_eff) - MAX_FRAME_BITS'(1));

    wfa_place #(
        .MAX_FRAME_BITS (MAX_FRAME_BITS)
    ) u_place (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .site_code     (site_code),
        .badge_number  (badge_number),
        .facility_mask (facility_mask_reg),
        .card_mask     (card_mask_reg),
        .span          (span),
        .dn_ctrl       (link_ctrl[0]),
        .dn_frame      (link_frame[0]),
        .dn_ready      (link_ready[0])
    );

    // Parity slots are applied in order, one stage each, so that a later
    // slot sees the bits set by earlier ones.
    for (genvar k = 0; k < PARITY_SLOTS; k++)
    begin : g_slot
        wfa_parity_stage #(
            .MAX_FRAME_BITS (MAX_FRAME_BITS),
            .SLOT           (k)
        ) u_parity (
            .clk             (clk),
            .rst_n           (rst_n),
            .up_ctrl         (link_ctrl[k]),
            .up_frame        (link_frame[k]),
            .up_ready        (link_ready[k]),
            .parity_mask     (parity_mask_reg[k]),
            .parity_settings (parity_settings_reg),
            .span            (span),
            .len_eff         (len_eff),
            .dn_ctrl         (link_ctrl[k+1]),
            .dn_frame        (link_frame[k+1]),
            .dn_ready        (link_ready[k+1])
        );
    end

    assign link_ready[PARITY_SLOTS] = result_ready;
    assign result_valid = link_ctrl[PARITY_SLOTS].valid;
    assign status       = link_ctrl[PARITY_SLOTS].status;
    assign frame        = link_frame[PARITY_SLOTS];

    // Any error code comes with an all-zero frame.
    a_error_zero_frame: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != wfa_pkg::STATUS_OK) |-> frame == '0)
        else $error("error status delivered with a nonzero frame");

    // With the output register empty, every stage can move, so input is taken.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input stalled while the output register is empty");

    // A frame length write lands in its register on the next edge.
    a_cfg_length_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && (cfg_index == wfa_pkg::CFG_FRAME_LENGTH)
        |=> frame_length_reg == $past(cfg_data[LEN_W-1:0]))
        else $error("frame length write not taken");

endmodule
